[rtl/ift_pkg.sv]
// Package for the integer field formatter: shared widths, ASCII codes and the
// flag struct handed from the top level to the character emitter.
// No dependencies.
package ift_pkg;

    localparam int VALUE_W       = 32;
    localparam int NUM_DIGITS    = 10;
    localparam int BCD_W         = 4 * NUM_DIGITS;
    localparam int DIG_CNT_W     = $clog2(NUM_DIGITS + 1);
    localparam int FIELD_W       = 6;
    localparam int CHAR_W        = 7;
    localparam int MAX_WIDTH_DEF = 32;
    // Scratch width for field arithmetic; covers widths up to 64 plus a sign.
    localparam int CALC_W        = 8;

    localparam logic [CHAR_W-1:0] CH_STAR  = 7'h2A;
    localparam logic [CHAR_W-1:0] CH_BLANK = 7'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;

    typedef struct packed {
        logic neg;    // value is negative
        logic plus;   // print a plus sign before non-negative values
        logic blank;  // value is zero and no minimum digits: all blanks
    } t_fmt_flags;

endpackage

[rtl/ift_bcd_conv.sv]
// Bit-serial binary to BCD converter (shift and add-3), followed by a
// digit-serial normalization that drops leading zero digits.
// Depends on ift_pkg.
module ift_bcd_conv (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ift_pkg::VALUE_W-1:0]     i_mag,
    output logic                            o_done,
    output logic [ift_pkg::BCD_W-1:0]       o_bcd,
    output logic [ift_pkg::DIG_CNT_W-1:0]   o_ndig
);
    import ift_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_NORM
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [VALUE_W-1:0]    r_mag;
    logic [BCD_W-1:0]      r_bcd;
    logic [DIG_CNT_W-1:0]  r_ndig;
    logic                  r_done;
    logic [BCD_W-1:0]      n_adj;

    // Each digit of five or more gets three added before the shift.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mag   <= i_mag;
                        r_bcd   <= '0;
                        r_cnt   <= '0;
                        r_ndig  <= DIG_CNT_W'(NUM_DIGITS);
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_bcd <= {n_adj[BCD_W-2:0], r_mag[VALUE_W-1]};
                    r_mag <= {r_mag[VALUE_W-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_bcd[BCD_W-1 -: 4] == 4'd0 && r_ndig > DIG_CNT_W'(1)) begin
                        r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_ndig <= r_ndig - DIG_CNT_W'(1);
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;
    assign o_ndig = r_ndig;

endmodule

[rtl/ift_emit.sv]
// Character emitter: lays out blanks, sign, zero padding and digits of one
// field, one character per cycle, with digits shifted out a nibble at a time.
// Depends on ift_pkg.
module ift_emit #(
    parameter int MAX_WIDTH = ift_pkg::MAX_WIDTH_DEF,
    parameter int KW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ift_pkg::BCD_W-1:0]       i_bcd,
    input  logic [ift_pkg::DIG_CNT_W-1:0]   i_ndig,
    input  logic [KW-1:0]                   i_width,
    input  logic [ift_pkg::FIELD_W-1:0]     i_min,
    input  ift_pkg::t_fmt_flags             i_flags,
    output logic                            o_valid,
    output logic [ift_pkg::CHAR_W-1:0]      o_char,
    output logic                            o_last,
    output logic                            o_done
);
    import ift_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [KW-1:0]        r_pos;
    logic [KW-1:0]        r_spare;
    logic [KW-1:0]        r_dstart;
    logic                 r_ovf;
    logic                 r_has_sign;
    logic [BCD_W-1:0]     r_dig;
    logic                 r_valid;
    logic [CHAR_W-1:0]    r_char;
    logic                 r_last;
    logic                 r_done;

    logic                 n_xs;
    logic [CALC_W-1:0]    n_w, n_nd, n_m, n_sx, n_used;
    logic [CHAR_W-1:0]    n_char;
    logic                 n_is_digit;

    always_comb begin
        n_xs   = i_flags.neg || i_flags.plus;
        n_w    = CALC_W'(i_width);
        n_nd   = CALC_W'(i_ndig);
        n_m    = CALC_W'(i_min);
        n_sx   = CALC_W'(n_xs);
        n_used = (n_nd >= n_m) ? n_nd : n_m;
    end

    always_comb begin
        n_is_digit = 1'b0;
        if (r_ovf) begin
            n_char = CH_STAR;
        end else if (i_flags.blank || r_pos < r_spare) begin
            n_char = CH_BLANK;
        end else if (r_has_sign && r_pos == r_spare) begin
            n_char = i_flags.neg ? CH_MINUS : CH_PLUS;
        end else if (r_pos < r_dstart) begin
            n_char = CH_ZERO;
        end else begin
            n_char     = CH_ZERO + CHAR_W'(r_dig[BCD_W-1 -: 4]);
            n_is_digit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_done  <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dig   <= i_bcd;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_pos      <= '0;
                    r_ovf      <= !i_flags.blank &&
                                  ((n_nd + n_sx > n_w) || (n_m + n_sx > n_w));
                    r_has_sign <= n_xs;
                    r_spare    <= KW'(n_w - n_used - n_sx);
                    r_dstart   <= KW'(n_w - n_nd);
                    if (i_width == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_valid <= 1'b1;
                    r_char  <= n_char;
                    r_pos   <= r_pos + KW'(1);
                    if (n_is_digit) begin
                        r_dig <= {r_dig[BCD_W-5:0], 4'd0};
                    end
                    if (r_pos == i_width - KW'(1)) begin
                        r_last  <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;
    assign o_done  = r_done;

endmodule

[rtl/integer_field_formatter.sv]
// Top level of the integer field formatter: command port, the plus-sign
// register, and the chain of BCD converter and character emitter.
// Depends on ift_pkg, ift_bcd_conv and ift_emit.
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  ------------------------------------------
//  command   start high, busy low       i_value, i_value_is_short,
//                                       i_field_width, i_min_digits
//  result    o_char_valid, one cycle    o_char_out, o_last_char
//  config    i_cfg_we                   i_cfg_wdata (plus sign)
//
// The block takes a new item only when busy is low, after the emitter has
// finished the last one. Each item passes through the 32 steps of the
// bit-serial binary to BCD conversion, then the one-character-per-cycle
// emitter, which puts out as many characters as the saturated field width; a
// zero width emits nothing but still pays for the conversion. Reset is
// synchronous and clears all control state.
// The receiver cannot stall: every character is shown for exactly one cycle.
module integer_field_formatter #(
    parameter int MAX_WIDTH = ift_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_wdata,
    input  logic signed [ift_pkg::VALUE_W-1:0]   i_value,
    input  logic                                 i_value_is_short,
    input  logic [ift_pkg::FIELD_W-1:0]          i_field_width,
    input  logic [ift_pkg::FIELD_W-1:0]          i_min_digits,
    output logic                                 o_char_valid,
    output logic [ift_pkg::CHAR_W-1:0]           o_char_out,
    output logic                                 o_last_char
);
    import ift_pkg::*;

    localparam int KW = $clog2(MAX_WIDTH + 1);

    // Control state.
    logic                  r_plus_sign;
    logic                  r_busy;
    logic                  r_conv_go;

    // Item held for the whole time the block is busy.
    logic [VALUE_W-1:0]    r_mag;
    logic [KW-1:0]         r_width;
    logic [FIELD_W-1:0]    r_min;
    t_fmt_flags            r_flags;

    logic [VALUE_W-1:0]    n_ext;
    logic [VALUE_W-1:0]    n_mag;
    logic                  n_neg;
    logic                  n_sat;
    logic                  accept;

    logic                  conv_done;
    logic [BCD_W-1:0]      conv_bcd;
    logic [DIG_CNT_W-1:0]  conv_ndig;
    logic                  emit_done;

    assign accept = start && !r_busy;

    // The short form uses the low half of the value, sign-extended. The
    // magnitude of the most negative value still fits in 32 unsigned bits.
    always_comb begin
        if (i_value_is_short) begin
            n_ext = {{(VALUE_W/2){i_value[VALUE_W/2-1]}}, i_value[VALUE_W/2-1:0]};
        end else begin
            n_ext = i_value;
        end
        n_neg = n_ext[VALUE_W-1];
        n_mag = n_neg ? (VALUE_W'(0) - n_ext) : n_ext;
        // A field wider than the largest supported width is clamped to it.
        n_sat = {1'b0, i_field_width} > (FIELD_W + 1)'(MAX_WIDTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_sign <= 1'b0;
            r_busy      <= 1'b0;
            r_conv_go   <= 1'b0;
        end else begin
            r_conv_go <= 1'b0;
            if (i_cfg_we) begin
                r_plus_sign <= i_cfg_wdata;
            end
            if (accept) begin
                r_busy    <= 1'b1;
                r_conv_go <= 1'b1;
            end else if (emit_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Payload registers, loaded only when an item is accepted.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag         <= n_mag;
            r_width       <= n_sat ? KW'(MAX_WIDTH) : KW'(i_field_width);
            r_min         <= i_min_digits;
            r_flags.neg   <= n_neg;
            r_flags.plus  <= r_plus_sign;
            r_flags.blank <= (n_ext == '0) && (i_min_digits == '0);
        end
    end

    ift_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_conv_go),
        .i_mag   (r_mag),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd),
        .o_ndig  (conv_ndig)
    );

    ift_emit #(
        .MAX_WIDTH (MAX_WIDTH),
        .KW        (KW)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_done),
        .i_bcd   (conv_bcd),
        .i_ndig  (conv_ndig),
        .i_width (r_width),
        .i_min   (r_min),
        .i_flags (r_flags),
        .o_valid (o_char_valid),
        .o_char  (o_char_out),
        .o_last  (o_last_char),
        .o_done  (emit_done)
    );

    assign busy = r_busy;

`ifndef SYNTH
    // Characters only ever appear while an item is in progress.
    a_char_in_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_valid |-> busy)
        else $error("character emitted while no item is in progress");

    // The last character of a field ends the item.
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && o_last_char) |=> !busy)
        else $error("block still busy after the last character");

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");
`endif

endmodule
